// File: design/gace_pkg.sv
// Shared types, codes and helpers for the graph adjacency clustering engine.
package gace_pkg;

    localparam int NODE_W        = 4;
    localparam int MAX_ROWS      = 16;
    localparam int NODES_DEFAULT = 16;

    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMMON  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLUSTER = 2'd3;

    localparam int CMASK_W  = 16;
    localparam int CCOUNT_W = 5;
    localparam int DEG_W    = 5;
    localparam int NEDGE_W  = 7;
    localparam int COEF_W   = 17;
    localparam int IN_W     = 8;
    localparam int OUT_W    = 56;

    localparam int TWICE_W   = 8;
    localparam int PAIRS_W   = 8;
    localparam int FRAC_W    = 16;
    localparam int NUM_W     = TWICE_W + FRAC_W;
    localparam int DIV_STEPS = NUM_W;
    localparam int STEP_W    = 5;

    typedef logic [MAX_ROWS-1:0] row_t;

    function automatic logic [CCOUNT_W-1:0] popcount(input row_t x);
        logic [CCOUNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < MAX_ROWS; i++) begin
            c = c + {{(CCOUNT_W-1){1'b0}}, x[i]};
        end
        return c;
    endfunction

endpackage

// File: design/graph_adjacency_clustering_engine.sv
// Graph adjacency engine: matrix store, common-neighbour and clustering sequencer.
//
// Input channel s_*: one request per operation; s_tuser carries the mode
// (clear, add edge, common-neighbour query, clustering query), s_tdata the
// two node indices. Result channel m_*: exactly one result per request.
// s_tready is high only while the sequencer is idle; one request is worked
// on at a time through a single popcount unit, one row read port and a
// bit-serial divider.
// Steps per request (ROWS = min(NODES,16), k = degree): clear goes straight
//   to the result; add edge reads row a and, if both nodes are in range, writes row a and, unless a = b, row b;
//   common query reads rows a and b and masks them; clustering query reads row a,
//   scans all ROWS rows for its k neighbours, plus 24 restoring divider steps when k >= 2.
// A finished result sits in the output register; the next request is taken
// while it waits. If the receiver stalls with a result still held, the
// sequencer waits in its final state until the register frees up.
// Reset (aresetn low, synchronous) empties the graph via per-row valid bits
// and drops any held result; the block is ready the cycle after.
module graph_adjacency_clustering_engine
    import gace_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // node_a[3:0], node_b[7:4]
    input  logic [MODE_W-1:0] s_tuser,  // mode[1:0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // common_mask[15:0], common_count[20:16],
                                        // degree[25:21], neighbour_edges[32:26],
                                        // coefficient_q16[49:33], zero[55:50]
);

    localparam int ROWS  = (NODES < MAX_ROWS) ? NODES : MAX_ROWS;
    localparam int ROW_W = $clog2(ROWS);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_ADD_RD   = 4'd1;
    localparam logic [3:0] ST_ADD_WA   = 4'd2;
    localparam logic [3:0] ST_ADD_WB   = 4'd3;
    localparam logic [3:0] ST_CMN_RA   = 4'd4;
    localparam logic [3:0] ST_CMN_RB   = 4'd5;
    localparam logic [3:0] ST_CMN_AND  = 4'd6;
    localparam logic [3:0] ST_CLU_RA   = 4'd7;
    localparam logic [3:0] ST_CLU_NB   = 4'd8;
    localparam logic [3:0] ST_CLU_SCAN = 4'd9;
    localparam logic [3:0] ST_CLU_ACC  = 4'd10;
    localparam logic [3:0] ST_CLU_PREP = 4'd11;
    localparam logic [3:0] ST_CLU_DIV  = 4'd12;
    localparam logic [3:0] ST_DONE     = 4'd13;

    logic [ROWS-1:0] mem [ROWS];

    logic [3:0]          state_reg, state_next;
    logic [NODE_W-1:0]   a_reg, a_next, b_reg, b_next, j_reg, j_next;
    row_t                nb_reg, nb_next, acc_reg, acc_next;
    logic [DEG_W-1:0]    deg_reg, deg_next;
    logic [TWICE_W-1:0]  twice_reg, twice_next;
    logic [PAIRS_W-1:0]  pairs_reg, pairs_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [PAIRS_W:0]    rem_reg, rem_next;
    logic [COEF_W-1:0]   quo_reg, quo_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [CMASK_W-1:0]  cmask_reg, cmask_next;
    logic [CCOUNT_W-1:0] ccount_reg, ccount_next;
    logic [NEDGE_W-1:0]  nedge_reg, nedge_next;
    logic [COEF_W-1:0]   coef_reg, coef_next;
    logic [OUT_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [ROWS-1:0]     row_vld_reg, row_vld_next;
    logic [ROWS-1:0]     rd_data_reg;
    logic                rd_ok_reg;

    logic [NODE_W-1:0]   rd_node;
    logic                rd_ok;
    logic [ROW_W-1:0]    rd_addr;
    logic                wr_en;
    logic [ROW_W-1:0]    wr_addr;
    row_t                wr_row;
    row_t                rd_row;
    row_t                bit_a, bit_b, bit_j;
    row_t                pc_in;
    logic [CCOUNT_W-1:0] pc_out;
    logic                a_ok, b_ok, j_last;
    logic [PAIRS_W:0]    rem_sh;
    logic                rem_ge;
    logic [2*DEG_W-1:0]  pairs_full;

    function automatic logic node_in_range(input logic [NODE_W-1:0] n);
        return {1'b0, n} < (NODE_W+1)'(ROWS);
    endfunction

    assign a_ok   = node_in_range(a_reg);
    assign b_ok   = node_in_range(b_reg);
    assign j_last = ({1'b0, j_reg} == (NODE_W+1)'(ROWS - 1));
    assign bit_a  = row_t'(1) << a_reg;
    assign bit_b  = row_t'(1) << b_reg;
    assign bit_j  = row_t'(1) << j_reg;
    assign rd_row = rd_ok_reg ? row_t'(rd_data_reg) : '0;
    assign pc_out = popcount(pc_in);

    assign rem_sh     = {rem_reg[PAIRS_W-1:0], num_reg[NUM_W-1]};
    assign rem_ge     = rem_sh >= {1'b0, pairs_reg};
    assign pairs_full = (2*DEG_W)'(deg_reg) * (2*DEG_W)'(deg_reg - DEG_W'(1));

    always_comb begin
        case (state_reg)
            ST_ADD_WA, ST_CMN_RB: rd_node = b_reg;
            ST_CLU_SCAN:          rd_node = j_reg;
            default:              rd_node = a_reg;
        endcase
    end
    assign rd_ok   = node_in_range(rd_node);
    assign rd_addr = rd_node[ROW_W-1:0];

    always_comb begin
        case (state_reg)
            ST_CMN_AND: pc_in = acc_reg & rd_row & ~bit_a & ~bit_b;
            ST_CLU_NB:  pc_in = rd_row & ~bit_a;
            default:    pc_in = nb_reg & ~bit_j & rd_row;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = a_reg[ROW_W-1:0];
        wr_row  = rd_row | bit_b;
        if (state_reg == ST_ADD_WA) begin
            wr_en = 1'b1;
            if (a_reg == b_reg) begin
                wr_row = rd_row & ~bit_a;
            end
        end else if (state_reg == ST_ADD_WB) begin
            wr_en   = 1'b1;
            wr_addr = b_reg[ROW_W-1:0];
            wr_row  = rd_row | bit_a;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next    = state_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        j_next        = j_reg;
        nb_next       = nb_reg;
        acc_next      = acc_reg;
        deg_next      = deg_reg;
        twice_next    = twice_reg;
        pairs_next    = pairs_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;
        cmask_next    = cmask_reg;
        ccount_next   = ccount_reg;
        nedge_next    = nedge_reg;
        coef_next     = coef_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        row_vld_next  = row_vld_reg;
        if (wr_en) begin
            row_vld_next[wr_addr] = 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    a_next      = s_tdata[NODE_W-1:0];
                    b_next      = s_tdata[2*NODE_W-1:NODE_W];
                    cmask_next  = '0;
                    ccount_next = '0;
                    deg_next    = '0;
                    nedge_next  = '0;
                    coef_next   = '0;
                    case (s_tuser)
                        MODE_CLEAR: begin
                            row_vld_next = '0;
                            state_next   = ST_DONE;
                        end
                        MODE_ADD:    state_next = ST_ADD_RD;
                        MODE_COMMON: state_next = ST_CMN_RA;
                        default:     state_next = ST_CLU_RA;
                    endcase
                end
            end
            ST_ADD_RD: begin
                state_next = (a_ok && b_ok) ? ST_ADD_WA : ST_DONE;
            end
            ST_ADD_WA: begin
                state_next = (a_reg == b_reg) ? ST_DONE : ST_ADD_WB;
            end
            ST_ADD_WB: begin
                state_next = ST_DONE;
            end
            ST_CMN_RA: begin
                state_next = ST_CMN_RB;
            end
            ST_CMN_RB: begin
                acc_next   = rd_row;
                state_next = ST_CMN_AND;
            end
            ST_CMN_AND: begin
                cmask_next  = pc_in;
                ccount_next = pc_out;
                state_next  = ST_DONE;
            end
            ST_CLU_RA: begin
                state_next = ST_CLU_NB;
            end
            ST_CLU_NB: begin
                nb_next    = pc_in;
                deg_next   = pc_out;
                twice_next = '0;
                j_next     = '0;
                state_next = ST_CLU_SCAN;
            end
            ST_CLU_SCAN: begin
                if (nb_reg[j_reg]) begin
                    state_next = ST_CLU_ACC;
                end else if (j_last) begin
                    state_next = ST_CLU_PREP;
                end else begin
                    j_next = NODE_W'(j_reg + 1'b1);
                end
            end
            ST_CLU_ACC: begin
                twice_next = TWICE_W'(twice_reg + TWICE_W'(pc_out));
                if (j_last) begin
                    state_next = ST_CLU_PREP;
                end else begin
                    j_next     = NODE_W'(j_reg + 1'b1);
                    state_next = ST_CLU_SCAN;
                end
            end
            ST_CLU_PREP: begin
                if (deg_reg < DEG_W'(2)) begin
                    state_next = ST_DONE;
                end else begin
                    nedge_next = twice_reg[TWICE_W-1:1];
                    pairs_next = pairs_full[PAIRS_W-1:0];
                    num_next   = {twice_reg, {FRAC_W{1'b0}}};
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_CLU_DIV;
                end
            end
            ST_CLU_DIV: begin
                rem_next = rem_ge ? (rem_sh - {1'b0, pairs_reg}) : rem_sh;
                quo_next = {quo_reg[COEF_W-2:0], rem_ge};
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                cnt_next = STEP_W'(cnt_reg + 1'b1);
                if (cnt_reg == STEP_W'(DIV_STEPS - 1)) begin
                    coef_next  = {quo_reg[COEF_W-2:0], rem_ge};
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = OUT_W'({coef_reg, nedge_reg, deg_reg, ccount_reg,
                                            cmask_reg});
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row[ROWS-1:0];
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            row_vld_reg  <= '0;
            rd_ok_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            row_vld_reg  <= row_vld_next;
            rd_ok_reg    <= rd_ok && row_vld_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        j_reg       <= j_next;
        nb_reg      <= nb_next;
        acc_reg     <= acc_next;
        deg_reg     <= deg_next;
        twice_reg   <= twice_next;
        pairs_reg   <= pairs_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        cmask_reg   <= cmask_next;
        ccount_reg  <= ccount_next;
        nedge_reg   <= nedge_next;
        coef_reg    <= coef_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule
